FILE: rtl/floyd_steinberg_rgb_dither_defines.svh
// Assertion macros used by the checker file of the dither block.
`ifndef FLOYD_STEINBERG_RGB_DITHER_DEFINES_SVH
`define FLOYD_STEINBERG_RGB_DITHER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define FSRD_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define FSRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/fsrd_pkg.sv
// Shared constants, types and helper functions of the dither block.
`timescale 1ns / 1ps
package fsrd_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int ERR_FRAC   = 8;
	localparam int ERR_W      = ERR_FRAC + 8;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int CNT_W      = 12;
	localparam int DIM_W      = 13;
	localparam int LEV_W      = 9;
	localparam int ACC_W      = ERR_W + 4;
	localparam int E_W        = ACC_W + 1;
	localparam int T_W        = E_W + 3;
	localparam int DIV_W      = 12;
	localparam int DCNT_W     = 4;
	localparam int CH_W       = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_RED_LEVELS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_LEVELS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_LEVELS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

	localparam logic [CH_W-1:0] CH_RED   = 2'd0;
	localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
	localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_STEP,
		ST_STEP_WAIT,
		ST_QUOT,
		ST_QUOT_WAIT,
		ST_MUL,
		ST_UPD,
		ST_WR_LEFT,
		ST_WR_CUR,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_pix;
		logic cap_above;
		logic step_start;
		logic quot_start;
		logic mul;
		logic upd;
		logic wr_left;
		logic wr_cur;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic last_col;
		logic last_row;
		logic col_nz;
		logic last_chan;
		logic out_free;
	} sts_t;

	localparam logic signed [T_W-1:0] ERR_HI = T_W'(2**(ERR_W-1) - 1);
	localparam logic signed [T_W-1:0] ERR_LO = -ERR_HI - T_W'(1);

	function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [T_W-1:0] v);
		logic signed [T_W-1:0] r;
		if (v > ERR_HI) r = ERR_HI;
		else if (v < ERR_LO) r = ERR_LO;
		else r = v;
		return r[ERR_W-1:0];
	endfunction

	// Division by sixteen that truncates toward zero, as signed C division does.
	function automatic logic signed [T_W-1:0] div16(input logic signed [T_W-1:0] v);
		logic signed [T_W-1:0] a;
		a = v + (v[T_W-1] ? T_W'(15) : T_W'(0));
		return a >>> 4;
	endfunction

endpackage

FILE: rtl/fsrd_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module fsrd_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/fsrd_ctrl.sv
// Sequencer of the dither block: steps each pixel through its channels.
`timescale 1ns / 1ps
module fsrd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fsrd_pkg::sts_t sts,
	output fsrd_pkg::cmd_t cmd
);
	import fsrd_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_pix = 1'b1;
					state_d      = ST_READ;
				end
			end
			ST_READ: begin
				cmd.cap_above = 1'b1;
				state_d       = ST_STEP;
			end
			ST_STEP: begin
				cmd.step_start = 1'b1;
				state_d        = ST_STEP_WAIT;
			end
			ST_STEP_WAIT: begin
				if (sts.div_done) state_d = ST_QUOT;
			end
			ST_QUOT: begin
				cmd.quot_start = 1'b1;
				state_d        = ST_QUOT_WAIT;
			end
			ST_QUOT_WAIT: begin
				if (sts.div_done) state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = sts.last_chan ? ST_WR_LEFT : ST_STEP;
			end
			ST_WR_LEFT: begin
				cmd.wr_left = !sts.last_row && sts.col_nz;
				state_d     = ST_WR_CUR;
			end
			ST_WR_CUR: begin
				cmd.wr_cur = !sts.last_row && sts.last_col;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

FILE: rtl/fsrd_datapath.sv
// Datapath of the dither block: registers, shared divider, error arithmetic, line buffer.
`timescale 1ns / 1ps
module fsrd_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fsrd_pkg::cmd_t                      cmd,
	output fsrd_pkg::sts_t                      sts,
	input  logic [7:0]                          red_in,
	input  logic [7:0]                          green_in,
	input  logic [7:0]                          blue_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          red_out,
	output logic [7:0]                          green_out,
	output logic [7:0]                          blue_out,
	output logic                                frame_last,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [fsrd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fsrd_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fsrd_pkg::*;

	localparam int RAM_W = 3 * ERR_W;

	// Configuration registers.
	logic [LEV_W-1:0] red_lv_q, green_lv_q, blue_lv_q;
	logic [DIM_W-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_lv_q   <= LEV_W'(2);
			green_lv_q <= LEV_W'(2);
			blue_lv_q  <= LEV_W'(2);
			width_q    <= DIM_W'(640);
			height_q   <= DIM_W'(480);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RED_LEVELS:   red_lv_q   <= cfg_data[LEV_W-1:0];
				REG_GREEN_LEVELS: green_lv_q <= cfg_data[LEV_W-1:0];
				REG_BLUE_LEVELS:  blue_lv_q  <= cfg_data[LEV_W-1:0];
				REG_IMAGE_WIDTH:  width_q    <= cfg_data;
				REG_IMAGE_HEIGHT: height_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Position in the frame.
	logic [CNT_W-1:0] col_q, row_q;
	logic [DIM_W-1:0] w_clamp, h_clamp;
	logic             last_col, last_row;

	always_comb begin
		if (width_q == '0) w_clamp = DIM_W'(1);
		else if (width_q > DIM_W'(MAX_WIDTH)) w_clamp = DIM_W'(MAX_WIDTH);
		else w_clamp = width_q;
		if (height_q == '0) h_clamp = DIM_W'(1);
		else if (height_q > DIM_W'(MAX_HEIGHT)) h_clamp = DIM_W'(MAX_HEIGHT);
		else h_clamp = height_q;
	end

	assign last_col = ({1'b0, col_q} + DIM_W'(1)) >= w_clamp;
	assign last_row = ({1'b0, row_q} + DIM_W'(1)) >= h_clamp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.out_load) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	// Channel pointer.
	logic [CH_W-1:0] ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= CH_RED;
		end else if (cmd.load_pix) begin
			ch_q <= CH_RED;
		end else if (cmd.upd) begin
			ch_q <= ch_q + CH_W'(1);
		end
	end

	// Line buffer holding the next row's errors, red in the low bits.
	logic             ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [RAM_W-1:0] ram_wdata, ram_rdata;
	logic signed [ERR_W-1:0] left_q [3];
	logic signed [ERR_W-1:0] cur_q [3];

	assign ram_we    = cmd.wr_left || cmd.wr_cur;
	assign ram_waddr = cmd.wr_left ? (col_q - ADDR_W'(1)) : col_q;
	assign ram_wdata = cmd.wr_left ? {left_q[2], left_q[1], left_q[0]}
	                               : {cur_q[2], cur_q[1], cur_q[0]};

	fsrd_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_WIDTH)
	) u_line_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(col_q),
		.rdata(ram_rdata)
	);

	// Pixel and error registers.
	logic [7:0]              pix_q [3];
	logic signed [ERR_W-1:0] above_q [3];
	logic signed [ERR_W-1:0] right_q [3];
	logic signed [ERR_W-1:0] blc_q [3];
	logic signed [ERR_W-1:0] bc_q [3];
	logic [7:0]              res_q [3];

	always_ff @(posedge clk) begin
		if (cmd.load_pix) begin
			pix_q[0] <= red_in;
			pix_q[1] <= green_in;
			pix_q[2] <= blue_in;
		end
		if (cmd.cap_above) begin
			for (int c = 0; c < 3; c++) begin
				above_q[c] <= (row_q == '0) ? '0 : ram_rdata[c*ERR_W +: ERR_W];
			end
		end
	end

	// Shared restoring divider, one quotient bit per cycle.
	logic [DIV_W-1:0]  dq_q;
	logic [7:0]        rem_q, dv_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [8:0]        rem_sh;
	logic              rem_ge;

	// Per-channel arithmetic.
	logic [LEV_W-1:0]        lv_sel, lv_clamp;
	logic [7:0]              step_div;
	logic signed [ACC_W-1:0] acc_d, acc_q;
	logic [ACC_W-1:0]        acc_mag;
	logic [ACC_W:0]          t_sum;
	logic [7:0]              step_q;
	logic signed [12:0]      q_q;
	logic [19:0]             q_prod;

	always_comb begin
		case (ch_q)
			CH_RED:   lv_sel = red_lv_q;
			CH_GREEN: lv_sel = green_lv_q;
			CH_BLUE:  lv_sel = blue_lv_q;
			default:  lv_sel = blue_lv_q;
		endcase
		if (lv_sel < LEV_W'(2)) lv_clamp = LEV_W'(2);
		else if (lv_sel > LEV_W'(256)) lv_clamp = LEV_W'(256);
		else lv_clamp = lv_sel;
	end

	assign step_div = 8'(lv_clamp - LEV_W'(1));

	assign acc_d = $signed({{(ACC_W-8-ERR_FRAC){1'b0}}, pix_q[ch_q], {ERR_FRAC{1'b0}}})
	             + ACC_W'(above_q[ch_q]) + ACC_W'(right_q[ch_q]);

	assign acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	// Twice the magnitude plus one step, so that dividing by two steps rounds half away.
	assign t_sum = {acc_mag, 1'b0} + {{(ACC_W+1-8-ERR_FRAC){1'b0}}, dq_q[7:0], {ERR_FRAC{1'b0}}};

	assign q_prod = dq_q * step_q;

	assign rem_sh = {rem_q, dq_q[DIV_W-1]};
	assign rem_ge = rem_sh >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.step_start || cmd.quot_start) begin
			dcnt_q <= DCNT_W'(DIV_W);
		end else if (dcnt_q != '0) begin
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step_start) begin
			dq_q   <= DIV_W'(255);
			rem_q  <= '0;
			dv_q   <= step_div;
			acc_q  <= acc_d;
		end else if (cmd.quot_start) begin
			dq_q   <= t_sum[ACC_W -: DIV_W];
			rem_q  <= '0;
			dv_q   <= dq_q[7:0];
			step_q <= dq_q[7:0];
		end else if (dcnt_q != '0) begin
			rem_q <= rem_ge ? 8'(rem_sh - {1'b0, dv_q}) : rem_sh[7:0];
			dq_q  <= {dq_q[DIV_W-2:0], rem_ge};
		end
		if (cmd.mul) begin
			q_q <= acc_q[ACC_W-1] ? -$signed({1'b0, q_prod[11:0]})
			                      : $signed({1'b0, q_prod[11:0]});
		end
	end

	// Error terms of the current channel.
	logic signed [E_W-1:0]   err;
	logic signed [T_W-1:0]   e24, t7, t5, t3, t1;
	logic signed [ERR_W-1:0] blc_new;
	logic                    edge_clr;

	assign err = $signed({acc_q[ACC_W-1], acc_q}) - $signed({q_q, {ERR_FRAC{1'b0}}});
	assign e24 = T_W'(err);
	assign t7  = div16((e24 <<< 3) - e24);
	assign t5  = div16((e24 <<< 2) + e24);
	assign t3  = div16((e24 <<< 1) + e24);
	assign t1  = div16(e24);
	assign blc_new  = sat_err(T_W'(bc_q[ch_q]) + t5);
	assign edge_clr = last_col || last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				right_q[c] <= '0;
				blc_q[c]   <= '0;
				bc_q[c]    <= '0;
			end
		end else if (cmd.upd) begin
			right_q[ch_q] <= last_col ? '0 : sat_err(t7);
			blc_q[ch_q]   <= edge_clr ? '0 : blc_new;
			bc_q[ch_q]    <= edge_clr ? '0 : sat_err(t1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			left_q[ch_q] <= sat_err(T_W'(blc_q[ch_q]) + t3);
			cur_q[ch_q]  <= blc_new;
			if (q_q[12]) res_q[ch_q] <= 8'd0;
			else if (q_q[11:8] != '0) res_q[ch_q] <= 8'd255;
			else res_q[ch_q] <= q_q[7:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			red_out    <= res_q[0];
			green_out  <= res_q[1];
			blue_out   <= res_q[2];
			frame_last <= last_col && last_row;
		end
	end

	assign sts.div_done  = (dcnt_q == '0);
	assign sts.last_col  = last_col;
	assign sts.last_row  = last_row;
	assign sts.col_nz    = (col_q != '0);
	assign sts.last_chan = (ch_q == CH_BLUE);
	assign sts.out_free  = !out_valid || out_ready;
endmodule

FILE: rtl/floyd_steinberg_rgb_dither.sv
// Top level of the RGB error-diffusion dither block.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  input   | in_valid / in_ready   | red_in, green_in, blue_in
//  output  | out_valid / out_ready | red_out, green_out, blue_out, frame_last
//  config  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// The result beat is offered once its pixel has passed the sequencer: for each
// channel two passes of the shared 12-bit divider, step then rounded quotient,
// then a multiply and an update, with a read of the line buffer before the
// channels, writes of its left and current entries after them and a load of the
// output register. One pixel is in work at a time. The result waits in an output
// register, so the next pixel is taken while it stalls, but the following result
// waits for the stalled beat to go. Reset clears the counters, the carried errors,
// the configuration and the output valid flag; the line buffer needs no clearing.
`timescale 1ns / 1ps
module floyd_steinberg_rgb_dither (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      red_in,
	input  logic [7:0]                      green_in,
	input  logic [7:0]                      blue_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      red_out,
	output logic [7:0]                      green_out,
	output logic [7:0]                      blue_out,
	output logic                            frame_last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fsrd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fsrd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fsrd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	fsrd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	fsrd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.frame_last(frame_last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);
endmodule

FILE: rtl/fsrd_checker.sv
// Port-level checker of the dither block and its bind.
`timescale 1ns / 1ps
`include "floyd_steinberg_rgb_dither_defines.svh"
module fsrd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [7:0]                      red_in,
	input logic [7:0]                      green_in,
	input logic [7:0]                      blue_in,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [7:0]                      red_out,
	input logic [7:0]                      green_out,
	input logic [7:0]                      blue_out,
	input logic                            frame_last,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [fsrd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [fsrd_pkg::CFG_DATA_W-1:0] cfg_data
);
	// Configuration beats are always taken.
	`FSRD_ASSERT_NOW(a_cfg_ready, cfg_ready, "configuration port not ready")

	// Only one pixel is in work, so input closes right after a beat.
	`FSRD_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second pixel taken while busy")

	// A result never appears in the cycle after its pixel is taken while no beat waits.
	`FSRD_ASSERT_NEXT(a_no_early_beat, in_valid && in_ready && !out_valid, !out_valid, "result too early")

	// A stalled result stays put.
	`FSRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(frame_last), "stalled result changed")
endmodule

bind floyd_steinberg_rgb_dither fsrd_checker u_fsrd_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for the RGB error-diffusion dither block.
`timescale 1ns / 1ps
module testbench;
	import fsrd_pkg::*;

	localparam int LB_DEPTH   = 4096;
	localparam int UNIT       = 256;
	localparam int ERR_MAX    = 32767;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE     = 150;
	localparam int RAND_ITEMS = 1400;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       last;
	} dither_px_t;

	typedef enum logic [1:0] {ROW_PIX, ROW_CFG, ROW_RAND} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		int         a, b, c;
		bit         typed;
		dither_px_t want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            red_in = '0, green_in = '0, blue_in = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            red_out, green_out, blue_out;
	logic                  frame_last;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	floyd_steinberg_rgb_dither DUT (.*);

	always #10 clk = ~clk;

	// Shadow state of the dither pipeline.
	int         lev[3];
	int         img_w, img_h;
	int         line_err[LB_DEPTH][3];
	int         right_e[3], bl_carry[3], b_carry[3];
	int         col_cnt, row_cnt;
	dither_px_t pending_px[$];
	int         fails = 0;
	bit         fast = 0;
	plan_row_t  plan[$];

	function automatic int sat_e(input int v);
		if (v > ERR_MAX) return ERR_MAX;
		if (v < -ERR_MAX - 1) return -ERR_MAX - 1;
		return v;
	endfunction

	function automatic int quant_step(input int n);
		int k;
		k = (n < 2) ? 2 : ((n > 256) ? 256 : n);
		return 255 / (k - 1);
	endfunction

	function automatic int round_half_away(input int num, input int den);
		longint q;
		if (num >= 0) q = (longint'(num) * 2 + den) / (longint'(den) * 2);
		else q = -((longint'(-num) * 2 + den) / (longint'(den) * 2));
		return int'(q);
	endfunction

	task automatic dither_pixel(input int pix[3], output dither_px_t res);
		int w, h, x, y, stp, acc, q, e, o[3];
		bit lc, lr;
		w = (img_w < 1) ? 1 : ((img_w > LB_DEPTH) ? LB_DEPTH : img_w);
		h = (img_h < 1) ? 1 : ((img_h > 4096) ? 4096 : img_h);
		x = col_cnt % LB_DEPTH;
		y = row_cnt;
		lc = (x + 1 >= w);
		lr = (y + 1 >= h);
		for (int c = 0; c < 3; c++) begin
			stp = quant_step(lev[c]);
			acc = pix[c] * UNIT + ((y == 0) ? 0 : line_err[x][c]) + right_e[c];
			q = round_half_away(acc, stp * UNIT) * stp;
			e = acc - q * UNIT;
			o[c] = (q < 0) ? 0 : ((q > 255) ? 255 : q);
			right_e[c] = lc ? 0 : sat_e(e * 7 / 16);
			if (!lr) begin
				if (x > 0) line_err[x-1][c] = sat_e(bl_carry[c] + e * 3 / 16);
				bl_carry[c] = sat_e(b_carry[c] + e * 5 / 16);
				b_carry[c] = lc ? 0 : sat_e(e / 16);
				if (lc) line_err[x][c] = bl_carry[c];
			end
			if (lc || lr) begin
				bl_carry[c] = 0;
				b_carry[c] = 0;
			end
		end
		res.r = 8'(o[0]);
		res.g = 8'(o[1]);
		res.b = 8'(o[2]);
		res.last = lc && lr;
		if (lc) begin
			col_cnt = 0;
			row_cnt = lr ? 0 : (y + 1) & 12'hFFF;
		end else begin
			col_cnt = (x + 1) & 12'hFFF;
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (fast) return 0;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	function automatic int pick_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 0;
		if (r == 1) return 255;
		return $urandom_range(0, 255);
	endfunction

	function automatic int pick_levels();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return $urandom_range(2, 16);
		if (r == 6) return 256;
		if (r == 7) return $urandom_range(17, 255);
		if (r == 8) return $urandom_range(0, 1);
		return $urandom_range(257, 511);
	endfunction

	// One pixel beat; the expectation is the typed value where one is given.
	task automatic send_pixel(input int r, input int g, input int b, input bit typed,
			input dither_px_t want);
		int pix[3], gap;
		dither_px_t res;
		pix[0] = r;
		pix[1] = g;
		pix[2] = b;
		in_valid <= 1'b1;
		red_in <= 8'(r);
		green_in <= 8'(g);
		blue_in <= 8'(b);
		do @(posedge clk); while (!in_ready);
		dither_pixel(pix, res);
		pending_px.push_back(typed ? want : res);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		int v;
		in_valid <= 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		v = val & 13'h1FFF;
		case (idx)
			REG_RED_LEVELS:   lev[0] = v & 9'h1FF;
			REG_GREEN_LEVELS: lev[1] = v & 9'h1FF;
			REG_BLUE_LEVELS:  lev[2] = v & 9'h1FF;
			REG_IMAGE_WIDTH:  img_w = v;
			REG_IMAGE_HEIGHT: img_h = v;
			default: ;
		endcase
	endtask

	function automatic plan_row_t pix(input int r, g, b, input bit typed = 0,
			input dither_px_t want = '0);
		plan_row_t p;
		p.kind = ROW_PIX;
		p.a = r;
		p.b = g;
		p.c = b;
		p.typed = typed;
		p.want = want;
		return p;
	endfunction

	function automatic plan_row_t cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
		plan_row_t p;
		p = pix(0, 0, 0);
		p.kind = ROW_CFG;
		p.a = idx;
		p.b = val;
		return p;
	endfunction

	function automatic plan_row_t rnd(input int n);
		plan_row_t p;
		p = pix(0, 0, 0);
		p.kind = ROW_RAND;
		p.a = n;
		return p;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_px.size() == 0) begin
				$display("%0t: unexpected beat exp none act %h/%h/%h/%b", $time,
					red_out, green_out, blue_out, frame_last);
				fails++;
			end else begin
				dither_px_t w;
				w = pending_px.pop_front();
				if (red_out !== w.r) begin
					$display("%0t: red_out exp %0d act %0d", $time, w.r, red_out);
					fails++;
				end
				if (green_out !== w.g) begin
					$display("%0t: green_out exp %0d act %0d", $time, w.g, green_out);
					fails++;
				end
				if (blue_out !== w.b) begin
					$display("%0t: blue_out exp %0d act %0d", $time, w.b, blue_out);
					fails++;
				end
				if (frame_last !== w.last) begin
					$display("%0t: frame_last exp %b act %b", $time, w.last, frame_last);
					fails++;
				end
			end
		end
	end

	// Receiver holds ready at one level for random stretches.
	int ready_hold = 0;
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			out_ready <= fast || ($urandom_range(0, 2) != 0);
			ready_hold <= pick_gap();
		end
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int sent, w, h, frames;
		lev = '{2, 2, 2};
		img_w = 640;
		img_h = 480;
		right_e = '{0, 0, 0};
		bl_carry = '{0, 0, 0};
		b_carry = '{0, 0, 0};
		col_cnt = 0;
		row_cnt = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults straight after reset, then shrinking the frame mid-row.
		plan.push_back(pix(255, 0, 128, 1, '{8'd255, 8'd0, 8'd255, 1'b0}));
		plan.push_back(pix(0, 255, 255));
		plan.push_back(pix(128, 127, 1));
		plan.push_back(pix(254, 1, 0));
		plan.push_back(pix(127, 128, 129));
		plan.push_back(cfg(REG_IMAGE_WIDTH, 1));
		plan.push_back(cfg(REG_IMAGE_HEIGHT, 1));
		plan.push_back(pix(9, 9, 9));
		// With 256 levels a one-pixel frame passes samples through.
		plan.push_back(cfg(REG_RED_LEVELS, 256));
		plan.push_back(cfg(REG_GREEN_LEVELS, 256));
		plan.push_back(cfg(REG_BLUE_LEVELS, 256));
		plan.push_back(pix(0, 0, 0, 1, '{8'd0, 8'd0, 8'd0, 1'b1}));
		plan.push_back(pix(255, 255, 255, 1, '{8'd255, 8'd255, 8'd255, 1'b1}));
		plan.push_back(pix(170, 85, 1, 1, '{8'd170, 8'd85, 8'd1, 1'b1}));
		// Out-of-range level counts are clamped.
		plan.push_back(cfg(REG_RED_LEVELS, 0));
		plan.push_back(cfg(REG_GREEN_LEVELS, 1));
		plan.push_back(cfg(REG_BLUE_LEVELS, 511));
		plan.push_back(pix(200, 100, 37, 1, '{8'd255, 8'd0, 8'd37, 1'b1}));
		// Oversized width and zero height clamp; one realigning pixel follows.
		plan.push_back(cfg(REG_RED_LEVELS, 257));
		plan.push_back(cfg(REG_GREEN_LEVELS, 3));
		plan.push_back(cfg(REG_BLUE_LEVELS, 2));
		plan.push_back(cfg(REG_IMAGE_WIDTH, 8191));
		plan.push_back(cfg(REG_IMAGE_HEIGHT, 0));
		plan.push_back(rnd(4));
		plan.push_back(cfg(REG_IMAGE_WIDTH, 1));
		plan.push_back(rnd(1));
		// Height shrinks below the current row, which then ends the frame.
		plan.push_back(cfg(REG_IMAGE_WIDTH, 4));
		plan.push_back(cfg(REG_IMAGE_HEIGHT, 5));
		plan.push_back(rnd(9));
		plan.push_back(cfg(REG_IMAGE_HEIGHT, 2));
		plan.push_back(rnd(3));

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_PIX: send_pixel(plan[i].a, plan[i].b, plan[i].c, plan[i].typed,
					plan[i].want);
				ROW_CFG: write_reg(CFG_IDX_W'(plan[i].a), plan[i].b);
				default: repeat (plan[i].a)
					send_pixel(pick_sample(), pick_sample(), pick_sample(), 0, '0);
			endcase
		end

		// Random phases, each a whole number of frames but for the last, cut at the count.
		sent = 0;
		while (sent < RAND_ITEMS) begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
			h = $urandom_range(1, 6);
			frames = $urandom_range(1, 2);
			write_reg(REG_RED_LEVELS, pick_levels());
			write_reg(REG_GREEN_LEVELS, pick_levels());
			write_reg(REG_BLUE_LEVELS, pick_levels());
			write_reg(REG_IMAGE_WIDTH, w);
			write_reg(REG_IMAGE_HEIGHT, h);
			fast = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < w * h * frames && sent < RAND_ITEMS; k++) begin
				send_pixel(pick_sample(), pick_sample(), pick_sample(), 0, '0);
				sent++;
			end
			fast = 0;
		end
		in_valid <= 1'b0;

		while (pending_px.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: floyd_steinberg_rgb_dither.f
+incdir+rtl
rtl/fsrd_pkg.sv
rtl/fsrd_ram.sv
rtl/fsrd_ctrl.sv
rtl/fsrd_datapath.sv
rtl/floyd_steinberg_rgb_dither.sv
rtl/fsrd_checker.sv
tb/testbench.sv
